[hw/rtl/rme_pkg.sv]
`timescale 1ns / 1ps

package rme_pkg;

   // Width of the modulus, exponent and residue magnitude.
   localparam int MOD_BITS = 27;

   // Width of the signed symbol field.
   localparam int SYM_W = MOD_BITS + 2;

   // Offset between a character code and the value that is exponentiated.
   localparam int SYMBOL_OFFSET = 96;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((MOD_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * MOD_BITS + 3 + 7) / 8) * 8;

   // Bit-serial multiplier step counter: it counts MOD_BITS + 1 multiplier bits.
   localparam int STEP_W = $clog2(MOD_BITS + 2);

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENC_MODULUS  = 2'd0;
   localparam logic [1:0] CSR_ENC_EXPONENT = 2'd1;
   localparam logic [1:0] CSR_DEC_MODULUS  = 2'd2;
   localparam logic [1:0] CSR_DEC_EXPONENT = 2'd3;

   // Operation selected by the tuser bit of an input item.
   localparam logic KIND_ENCRYPT = 1'b0;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

[hw/rtl/rsa_modular_exponentiation_unit.sv]
`timescale 1ns / 1ps
// The work per item is set by the bit-serial modular multipliers, with square and
// multiply running side by side once per exponent bit; an exponent of zero or a modulus
// below two skips them.
// One item is in work at a time; a new item is taken only after the last result is emitted.
// Reset is synchronous and active high; it sets all four key registers to 1.
module rsa_modular_exponentiation_unit
   import rme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input item.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // operand (signed), zero fill
   input  logic                  req_tuser,  // kind: 0 encrypt, 1 decrypt
   // Result item.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // residue_magnitude, residue_negative,
                                             // symbol (signed), zero fill
   // Configuration writes.
   input  logic                  csr_wen,
   input  logic [1:0]            csr_index,
   input  logic [MOD_BITS-1:0]   csr_wdata
);

   // Key registers.
   logic [MOD_BITS-1:0] enc_mod_ff, enc_exp_ff, dec_mod_ff, dec_exp_ff;

   // Sequencer and datapath registers.
   state_type           state_ff, state_in;
   logic [MOD_BITS-1:0] n_ff, n_in;
   logic [MOD_BITS-1:0] e_ff, e_in;
   logic [MOD_BITS:0]   bmag_ff, bmag_in;
   logic                neg_cand_ff, neg_cand_in;
   logic [MOD_BITS-1:0] mag_ff, mag_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Multiplier hookup.
   logic                mul_start;
   logic [MOD_BITS-1:0] mul_a0;
   logic [MOD_BITS:0]   mul_b;
   logic                mul_done;
   logic                sq_done;
   logic [MOD_BITS-1:0] mul_p0, mul_p1;

   // Input decode.
   logic [MOD_BITS:0]   operand;
   logic [SYM_W-1:0]    base;
   logic [SYM_W-1:0]    base_abs;
   logic [MOD_BITS-1:0] sel_exp;

   // Result formatting.
   logic                res_neg;
   logic [SYM_W-1:0]    res_ext;
   logic [SYM_W-1:0]    res_signed;
   logic [SYM_W-1:0]    symbol;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enc_mod_ff <= MOD_BITS'(1);
         enc_exp_ff <= MOD_BITS'(1);
         dec_mod_ff <= MOD_BITS'(1);
         dec_exp_ff <= MOD_BITS'(1);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_ENC_MODULUS:  enc_mod_ff <= csr_wdata;
            CSR_ENC_EXPONENT: enc_exp_ff <= csr_wdata;
            CSR_DEC_MODULUS:  dec_mod_ff <= csr_wdata;
            CSR_DEC_EXPONENT: dec_exp_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Base magnitude and sign of the incoming item.
   always_comb begin
      operand  = req_tdata[MOD_BITS:0];
      base     = {operand[MOD_BITS], operand};
      if (req_tuser == KIND_ENCRYPT) begin
         base = base - SYM_W'(SYMBOL_OFFSET);
      end
      base_abs = base[SYM_W-1] ? -base : base;
      sel_exp  = (req_tuser == KIND_ENCRYPT) ? enc_exp_ff : dec_exp_ff;
   end

   // Signed result and its offset form.
   always_comb begin
      res_neg    = neg_cand_ff && (acc_ff != '0);
      res_ext    = {2'b00, acc_ff};
      res_signed = res_neg ? -res_ext : res_ext;
      symbol     = res_signed + SYM_W'(SYMBOL_OFFSET);
   end

   // Sequencer: reduce the base, then one square and one multiply per exponent bit.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      bmag_in      = bmag_ff;
      neg_cand_in  = neg_cand_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_a0       = acc_ff;
      mul_b        = {1'b0, mag_ff};
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               n_in        = (req_tuser == KIND_ENCRYPT) ? enc_mod_ff : dec_mod_ff;
               e_in        = sel_exp;
               bmag_in     = base_abs[MOD_BITS:0];
               neg_cand_in = base[SYM_W-1] && sel_exp[0];
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            if (e_ff == '0) begin
               acc_in   = MOD_BITS'(1);
               state_in = ST_EMIT;
            end else if (n_ff <= MOD_BITS'(1)) begin
               acc_in   = '0;
               state_in = ST_EMIT;
            end else begin
               // Base mod n as 1 * base mod n.
               mul_start = 1'b1;
               mul_a0    = MOD_BITS'(1);
               mul_b     = bmag_ff;
               state_in  = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               mag_in   = mul_p0;
               acc_in   = MOD_BITS'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (e_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               if (e_ff[0]) begin
                  acc_in = mul_p0;
               end
               mag_in   = mul_p1;
               e_in     = e_ff >> 1;
               state_in = ST_CHECK;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({symbol, res_neg, acc_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      e_ff        <= e_in;
      bmag_ff     <= bmag_in;
      neg_cand_ff <= neg_cand_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Multiply unit: acc * mag, or 1 * base during the reduction.
   rme_mulmod u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a0),
      .b     (mul_b),
      .n     (n_ff),
      .done  (mul_done),
      .p     (mul_p0)
   );

   // Square unit: mag * mag, finishing in the same cycle as the multiply unit.
   rme_mulmod u_sqr (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mag_ff),
      .b     (mul_b),
      .n     (n_ff),
      .done  (sq_done),
      .p     (mul_p1)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Both units start together and must finish together.
   always_ff @(posedge clock) begin
      if (!reset && (sq_done != mul_done)) begin
         $error("square and multiply units out of step");
      end
   end

endmodule

[hw/rtl/rme_mulmod.sv]
`timescale 1ns / 1ps

// Bit-serial modular multiplier: p = (a * b) mod n, with a < n and n >= 2.
// The multiplier b is scanned from its top bit down, one bit per cycle, over
// MOD_BITS + 1 bits. The product is valid while done is high.
module rme_mulmod
   import rme_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] a,
   input  logic [MOD_BITS:0]   b,
   input  logic [MOD_BITS-1:0] n,
   output logic                done,
   output logic [MOD_BITS-1:0] p
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] a_ff, a_in;
   logic [MOD_BITS-1:0] n_ff, n_in;
   logic [MOD_BITS:0]   b_ff, b_in;

   logic [MOD_BITS:0]   dbl;
   logic [MOD_BITS:0]   dbl_red;
   logic [MOD_BITS:0]   sum;
   logic [MOD_BITS:0]   sum_red;
   logic [MOD_BITS:0]   n_ext;

   // One step: double the partial product, reduce, add a if the bit is set, reduce.
   always_comb begin
      n_ext   = {1'b0, n_ff};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= n_ext) ? dbl - n_ext : dbl;
      sum     = dbl_red + (b_ff[MOD_BITS] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= n_ext) ? sum - n_ext : sum;
   end

   // Step control and operand loading.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      n_in    = n_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = a;
         n_in    = n;
         b_in    = b;
      end else if (busy_ff) begin
         acc_in = sum_red[MOD_BITS-1:0];
         b_in   = {b_ff[MOD_BITS-1:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(MOD_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      n_ff   <= n_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

[hw/rtl/rme_checker.sv]
`timescale 1ns / 1ps

module rme_checker
   import rme_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [MOD_BITS-1:0] chk_mag;
   logic                chk_neg;
   logic [SYM_W-1:0]    chk_sym;
   logic [SYM_W-1:0]    chk_expect;

   always_comb begin
      chk_mag    = rsp_tdata[MOD_BITS-1:0];
      chk_neg    = rsp_tdata[MOD_BITS];
      chk_sym    = rsp_tdata[2*MOD_BITS+2:MOD_BITS+1];
      chk_expect = (chk_neg ? -{2'b00, chk_mag} : {2'b00, chk_mag})
                   + SYM_W'(SYMBOL_OFFSET);
   end

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A negative result never has a zero magnitude.
   a_neg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && chk_neg |-> chk_mag != '0)
      else $error("negative flag on a zero residue");

   // The symbol field is the signed residue plus the offset.
   a_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> chk_sym == chk_expect)
      else $error("symbol does not match residue");

   // An accepted item keeps the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   // Reset leaves no result pending.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind rsa_modular_exponentiation_unit rme_checker u_rme_checker (.*);

[test/tb_rsa_modular_exponentiation_unit.sv]
`timescale 1ns / 1ps

module tb_rsa_modular_exponentiation_unit;
   import rme_pkg::*;

   localparam logic        KIND_DECRYPT = 1'b1;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int          DRAIN_CYCLES = 900;
   localparam int          OPND_W       = MOD_BITS + 1;
   localparam logic [MOD_BITS-1:0] KEY_MAX = {MOD_BITS{1'b1}};

   // Order in which a key set is written.
   localparam logic [1:0] KEY_ORDER [4] = '{CSR_ENC_MODULUS, CSR_ENC_EXPONENT,
                                            CSR_DEC_MODULUS, CSR_DEC_EXPONENT};

   typedef logic [MOD_BITS-1:0] key_set_type [4];

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [MOD_BITS-1:0] magnitude;
      logic                negative;
      logic [MOD_BITS+1:0] symbol;
   } residue_type;

   // Predicts the signed modular power of each accepted item and checks results in order.
   class residue_scoreboard;
      logic [MOD_BITS-1:0] enc_modulus  = MOD_BITS'(1);
      logic [MOD_BITS-1:0] enc_exponent = MOD_BITS'(1);
      logic [MOD_BITS-1:0] dec_modulus  = MOD_BITS'(1);
      logic [MOD_BITS-1:0] dec_exponent = MOD_BITS'(1);
      residue_type         awaited [$];
      int                  fail_count   = 0;

      function void write_key(logic [1:0] index, logic [MOD_BITS-1:0] value);
         case (index)
            CSR_ENC_MODULUS:  enc_modulus  = value;
            CSR_ENC_EXPONENT: enc_exponent = value;
            CSR_DEC_MODULUS:  dec_modulus  = value;
            CSR_DEC_EXPONENT: dec_exponent = value;
            default: ;
         endcase
      endfunction

      // Square-and-multiply on the magnitude; a zero exponent always gives one.
      function longint unsigned power_mod(longint unsigned base, longint unsigned expo,
                                          longint unsigned modulus);
         longint unsigned acc;
         acc = 1;
         if (expo == 0) return 1;
         if (modulus <= 1) return 0;
         base = base % modulus;
         while (expo != 0) begin
            if (expo[0]) acc = (acc * base) % modulus;
            base = (base * base) % modulus;
            expo = expo >> 1;
         end
         return acc;
      endfunction

      function void note_request(logic kind, logic [MOD_BITS:0] operand);
         longint              base;
         longint unsigned     modulus;
         longint unsigned     expo;
         longint unsigned     mag;
         logic signed [63:0]  signed_result;
         residue_type         res;
         base = 64'($signed(operand));
         if (kind == KIND_ENCRYPT) begin
            modulus = 64'(enc_modulus);
            expo    = 64'(enc_exponent);
            base    = base - SYMBOL_OFFSET;
         end else begin
            modulus = 64'(dec_modulus);
            expo    = 64'(dec_exponent);
         end
         mag = power_mod((base < 0) ? -base : base, expo, modulus);
         res.magnitude = mag[MOD_BITS-1:0];
         res.negative  = (base < 0) && expo[0] && (mag != 0);
         signed_result = res.negative ? -longint'(mag) : longint'(mag);
         signed_result = signed_result + SYMBOL_OFFSET;
         res.symbol    = signed_result[MOD_BITS+1:0];
         awaited.push_back(res);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         residue_type want;
         residue_type got;
         got.magnitude = data[MOD_BITS-1:0];
         got.negative  = data[MOD_BITS];
         got.symbol    = data[2*MOD_BITS+2:MOD_BITS+1];
         if (awaited.size() == 0) begin
            $error("result item with nothing awaited: tdata %h", data);
            fail_count++;
            return;
         end
         want = awaited.pop_front();
         if (got.magnitude !== want.magnitude) begin
            $error("residue_magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
            fail_count++;
         end
         if (got.negative !== want.negative) begin
            $error("residue_negative: expected %0d, got %0d", want.negative, got.negative);
            fail_count++;
         end
         if (got.symbol !== want.symbol) begin
            $error("symbol: expected %0d, got %0d",
                   $signed(want.symbol), $signed(got.symbol));
            fail_count++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [1:0]            csr_index  = CSR_ENC_MODULUS;
   logic [MOD_BITS-1:0]   csr_wdata  = '0;

   residue_scoreboard ledger = new();
   idle_mode_type     idle_mode = IDLE_NONE;
   key_set_type       active_keys = '{default: MOD_BITS'(1)};
   int unsigned       cycle_count = 0;

   rsa_modular_exponentiation_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Give up when the run takes far longer than the slowest correct one.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_rsa_modular_exponentiation_unit: FAIL");
         $finish;
      end
   end

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER: return 81;
         IDLE_BOTH:   return 38;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 81;
         IDLE_BOTH:     return 38;
         default:       return 0;
      endcase
   endfunction

   // Check each accepted result item and stall the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) ledger.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   // Offer one item, with a random gap in front, and wait until it is taken.
   task automatic send_item(logic kind, logic [MOD_BITS:0] operand);
      if ($urandom_range(99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct());
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(operand);
      do @(posedge clock); while (!req_tready);
      ledger.note_request(kind, operand);
   endtask

   // Hold off the sender until every awaited result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   // Write a whole key set while the block is idle.
   task automatic write_keys(key_set_type keys);
      for (int i = 0; i < 4; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= KEY_ORDER[i];
         csr_wdata <= keys[i];
         @(posedge clock);
         ledger.write_key(KEY_ORDER[i], keys[i]);
      end
      csr_wen <= 1'b0;
      active_keys = keys;
   endtask

   function automatic logic [MOD_BITS-1:0] random_modulus();
      if ($urandom_range(1)) return MOD_BITS'($urandom);
      return MOD_BITS'($urandom_range(2, 65535));
   endfunction

   // Exponents of random bit length so that the work per item varies.
   function automatic logic [MOD_BITS-1:0] random_exponent();
      logic [MOD_BITS-1:0] mask;
      mask = KEY_MAX >> $urandom_range(MOD_BITS);
      return MOD_BITS'($urandom) & mask;
   endfunction

   // Mostly printable characters and in-range residues, with raw patterns mixed in.
   task automatic send_random_item();
      logic              kind;
      logic [MOD_BITS:0] operand;
      logic [MOD_BITS:0] modulus;
      kind = 1'($urandom_range(1));
      if ($urandom_range(9) < 3) begin
         operand = OPND_W'($urandom);
      end else if (kind == KIND_ENCRYPT) begin
         operand = OPND_W'($urandom_range(32, 126));
      end else begin
         modulus = {1'b0, active_keys[CSR_DEC_MODULUS]};
         operand = (modulus > 1) ? OPND_W'($urandom % modulus)
                                 : OPND_W'($urandom_range(3));
         if ($urandom_range(1)) operand = -operand;
      end
      send_item(kind, operand);
   endtask

   initial begin
      key_set_type keys;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the widest keys: extremes of the operand and zero results.
      write_keys('{KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX});
      send_item(KIND_ENCRYPT, '0);
      send_item(KIND_ENCRYPT, OPND_W'(SYMBOL_OFFSET));
      send_item(KIND_ENCRYPT, OPND_W'(SYMBOL_OFFSET - 1));
      send_item(KIND_ENCRYPT, OPND_W'(SYMBOL_OFFSET + 1));
      send_item(KIND_ENCRYPT, OPND_W'(122));
      send_item(KIND_ENCRYPT, OPND_W'(32));
      send_item(KIND_ENCRYPT, {1'b0, KEY_MAX});
      send_item(KIND_ENCRYPT, {1'b1, {MOD_BITS{1'b0}}});
      send_item(KIND_ENCRYPT, -{1'b0, KEY_MAX});
      send_item(KIND_DECRYPT, '0);
      send_item(KIND_DECRYPT, OPND_W'(1));
      send_item(KIND_DECRYPT, OPND_W'(-1));
      send_item(KIND_DECRYPT, OPND_W'(2));
      send_item(KIND_DECRYPT, OPND_W'(-2));
      send_item(KIND_DECRYPT, {1'b0, KEY_MAX});
      send_item(KIND_DECRYPT, -{1'b0, KEY_MAX});
      send_item(KIND_DECRYPT, {1'b1, {MOD_BITS{1'b0}}});
      send_item(KIND_DECRYPT, OPND_W'(12345678));
      send_item(KIND_DECRYPT, OPND_W'(-98765432));
      send_item(KIND_DECRYPT, {1'b0, {MOD_BITS{1'b1}}} - 1'b1);
      repeat (40) send_random_item();
      wait_drained();

      // Random phases: fixed corner key sets first, then random keys.
      for (int phase = 1; phase <= 8; phase++) begin
         case (phase)
            1: keys = '{MOD_BITS'(3233), MOD_BITS'(17), MOD_BITS'(3233), MOD_BITS'(2753)};
            2: keys = '{MOD_BITS'(1), MOD_BITS'(0), MOD_BITS'(0), MOD_BITS'(0)};
            3: keys = '{MOD_BITS'(0), MOD_BITS'(5), MOD_BITS'(1), KEY_MAX};
            default: keys = '{random_modulus(), random_exponent(),
                              random_modulus(), random_exponent()};
         endcase
         write_keys(keys);
         idle_mode = idle_mode_type'(phase % 4);
         for (int n = 0; n < 45; n++) begin
            send_random_item();
            if ($urandom_range(39) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.fail_count == 0 && ledger.pending() == 0) begin
         $display("tb_rsa_modular_exponentiation_unit: PASS");
      end else begin
         $display("tb_rsa_modular_exponentiation_unit: FAIL");
      end
      $finish;
   end

endmodule
